[hdl/abs_pkg.sv]
package abs_pkg;

  localparam int DEF_NUM_TYPES = 7;

  // function codes
  localparam logic [2:0] FN_BOOT_CHECK  = 3'd0;
  localparam logic [2:0] FN_BOOT_REPORT = 3'd1;
  localparam logic [2:0] FN_SWITCH      = 3'd2;
  localparam logic [2:0] FN_UPGRADE     = 3'd3;
  localparam logic [2:0] FN_QUERY       = 3'd4;

  localparam logic       CODE_OK   = 1'b0;
  localparam logic       CODE_FAIL = 1'b1;

  localparam logic [7:0]  TRIES_RST    = 8'd3;
  localparam logic [7:0]  TRIES_MAX    = 8'hFF;
  localparam logic [1:0]  SUCCESS_GOAL = 2'd3;
  localparam logic [31:0] UPGRADE_CRC  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_ACTIVE  = 2'd2,
    ST_UNBOOT  = 2'd3
  } slot_status_t;

  typedef struct packed {
    slot_status_t status;
    logic [7:0]   tries;
    logic [1:0]   succ;
    logic [31:0]  version;
    logic [31:0]  size;
    logic [31:0]  crc;
  } slot_rec_t;

  // one row per firmware type: active bit and both slot records
  typedef struct packed {
    logic      active;
    slot_rec_t slot_b;
    slot_rec_t slot_a;
  } type_row_t;

  localparam int ROW_W = $bits(type_row_t);

  localparam type_row_t ROW_RST = '{
    active: 1'b0,
    slot_b: '{status: ST_IDLE, tries: 8'd0, succ: 2'd0,
              version: 32'd0, size: 32'd0, crc: 32'd0},
    slot_a: '{status: ST_PENDING, tries: 8'd0, succ: 2'd0,
              version: 32'd0, size: 32'd0, crc: 32'd0}
  };

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture input beat, issue row read
    logic load;    // write back row, load result register
  } abs_cmd_t;

endpackage

[hdl/ab_slot_boot_selector.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_func, in_fw_type, in_boot_ok, in_slot_pick,
//         |           |                       | in_new_version, in_new_size
// out     | output    | out_valid / out_ready | out_status_code .. out_slot_crc
// cfg     | input     | cfg_wr_en             | cfg_wr_data (max boot tries)
//
// an event goes through accept, row read from the type table ram, update and write back, in that order
// the type table ram has one registered read port; a new event is accepted only after the last leaves the update step
// rst_n (sync, active low) clears the controller and the row valid flags, and sets max tries to 3
// rows never written since reset read as slot a pending, slot b idle, all counts zero
// a beat waits in the update step while the result register is full and out_ready is low
module ab_slot_boot_selector #(
  parameter int NUM_TYPES = abs_pkg::DEF_NUM_TYPES
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // event beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [2:0]  in_fw_type,
  input  logic        in_boot_ok,
  input  logic        in_slot_pick,
  input  logic [31:0] in_new_version,
  input  logic [31:0] in_new_size,
  // result beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status_code,
  output logic        out_active_now,
  output logic [1:0]  out_slot_state,
  output logic [7:0]  out_tries,
  output logic [1:0]  out_successes,
  output logic [31:0] out_slot_version,
  output logic [31:0] out_slot_size,
  output logic [31:0] out_slot_crc
);
  import abs_pkg::*;

  localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  abs_cmd_t         cmd;
  logic             ram_re, ram_we;
  logic [AW-1:0]    ram_raddr, ram_waddr;
  logic [ROW_W-1:0] ram_rdata, ram_wdata;

  // sequencing and result-register occupancy
  abs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // record update logic, config register and result register
  abs_dpath #(
    .NUM_TYPES (NUM_TYPES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_func          (in_func),
    .in_fw_type       (in_fw_type),
    .in_boot_ok       (in_boot_ok),
    .in_slot_pick     (in_slot_pick),
    .in_new_version   (in_new_version),
    .in_new_size      (in_new_size),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .out_status_code  (out_status_code),
    .out_active_now   (out_active_now),
    .out_slot_state   (out_slot_state),
    .out_tries        (out_tries),
    .out_successes    (out_successes),
    .out_slot_version (out_slot_version),
    .out_slot_size    (out_slot_size),
    .out_slot_crc     (out_slot_crc)
  );

  // one row per firmware type: active bit plus both slot records
  abs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_TYPES)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hdl/abs_ram.sv]
module abs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/abs_ctrl.sv]
module abs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output abs_pkg::abs_cmd_t cmd
);
  import abs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;

  assign in_ready   = (state_r == S_IDLE);
  assign load       = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.load   = load;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/abs_dpath.sv]
module abs_dpath #(
  parameter int NUM_TYPES = abs_pkg::DEF_NUM_TYPES,
  localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  abs_pkg::abs_cmd_t cmd,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic [2:0]        in_func,
  input  logic [2:0]        in_fw_type,
  input  logic              in_boot_ok,
  input  logic              in_slot_pick,
  input  logic [31:0]       in_new_version,
  input  logic [31:0]       in_new_size,
  // row memory port
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [abs_pkg::ROW_W-1:0] ram_rdata,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [abs_pkg::ROW_W-1:0] ram_wdata,
  // result register
  output logic              out_status_code,
  output logic              out_active_now,
  output logic [1:0]        out_slot_state,
  output logic [7:0]        out_tries,
  output logic [1:0]        out_successes,
  output logic [31:0]       out_slot_version,
  output logic [31:0]       out_slot_size,
  output logic [31:0]       out_slot_crc
);
  import abs_pkg::*;

  logic [7:0]  max_tries_r;
  logic [2:0]  func_r;
  logic [2:0]  fw_type_r;
  logic        boot_ok_r;
  logic        pick_r;
  logic [31:0] ver_r;
  logic [31:0] size_r;
  logic        bad_r;
  logic        row_vld_r;
  logic [NUM_TYPES-1:0] vld_r, vld_nxt;

  logic        bad_in;
  logic        hit_vld;
  type_row_t   row_cur, row_new;
  slot_rec_t   cur_act, cur_oth, new_act, new_oth, rep_rec;
  logic        act, oth, act_new, rep, code;
  logic [7:0]  tries_inc;
  logic [1:0]  succ_inc;

  assign bad_in    = (int'(in_fw_type) >= NUM_TYPES);
  assign ram_re    = cmd.accept && !bad_in;
  assign ram_raddr = AW'(in_fw_type);

  // valid flag of the row being read, rows never written read as reset
  always_comb begin
    hit_vld = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (int'(in_fw_type) == i) hit_vld = vld_r[i];
    end
  end

  always_comb begin
    row_cur = row_vld_r ? type_row_t'(ram_rdata) : ROW_RST;
    act     = row_cur.active;
    oth     = !act;
    cur_act = act ? row_cur.slot_b : row_cur.slot_a;
    cur_oth = act ? row_cur.slot_a : row_cur.slot_b;
    new_act = cur_act;
    new_oth = cur_oth;
    act_new = act;
    code    = CODE_OK;
    tries_inc = (cur_act.tries == TRIES_MAX) ? cur_act.tries : cur_act.tries + 8'd1;
    succ_inc  = (boot_ok_r && cur_act.succ < SUCCESS_GOAL) ? cur_act.succ + 2'd1
                                                             : cur_act.succ;
    unique case (func_r)
      FN_BOOT_CHECK: begin
        if (cur_act.status == ST_PENDING) begin
          new_act.tries = tries_inc;
          if (tries_inc > max_tries_r) begin
            new_act.status = ST_UNBOOT;
            if (cur_oth.status == ST_PENDING || cur_oth.status == ST_ACTIVE) begin
              act_new = oth;
              if (cur_oth.status == ST_PENDING) new_oth.tries = 8'd1;
            end else begin
              code = CODE_FAIL;
            end
          end
        end else if (cur_act.status != ST_ACTIVE) begin
          if (cur_oth.status == ST_PENDING || cur_oth.status == ST_ACTIVE) begin
            act_new = oth;
            if (cur_oth.status == ST_PENDING) new_oth.tries = 8'd1;
          end else begin
            code = CODE_FAIL;
          end
        end
      end
      FN_BOOT_REPORT: begin
        if (cur_act.status != ST_ACTIVE) begin
          new_act.succ = succ_inc;
          if (succ_inc >= SUCCESS_GOAL) begin
            new_act.status = ST_ACTIVE;
            new_act.succ   = 2'd1;
          end
        end
      end
      FN_SWITCH: begin
        if (cur_oth.status == ST_PENDING || cur_oth.status == ST_ACTIVE) begin
          act_new = oth;
        end else begin
          code = CODE_FAIL;
        end
      end
      FN_UPGRADE: begin
        new_oth = '{status: ST_PENDING, tries: 8'd0, succ: 2'd0,
                    version: ver_r, size: size_r, crc: UPGRADE_CRC};
        act_new = oth;
      end
      FN_QUERY: ;
      default: code = CODE_FAIL;
    endcase
    row_new.active = act_new;
    row_new.slot_a = act ? new_oth : new_act;
    row_new.slot_b = act ? new_act : new_oth;
    rep     = (func_r == FN_QUERY) ? pick_r : act_new;
    rep_rec = rep ? row_new.slot_b : row_new.slot_a;
  end

  assign ram_we    = cmd.load && !bad_r;
  assign ram_waddr = AW'(fw_type_r);
  assign ram_wdata = row_new;

  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (ram_we && int'(fw_type_r) == i) vld_nxt[i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r <= TRIES_RST;
      vld_r       <= '0;
    end else begin
      if (cfg_wr_en) max_tries_r <= cfg_wr_data;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r    <= in_func;
      fw_type_r <= in_fw_type;
      boot_ok_r <= in_boot_ok;
      pick_r    <= in_slot_pick;
      ver_r     <= in_new_version;
      size_r    <= in_new_size;
      bad_r     <= bad_in;
      row_vld_r <= hit_vld;
    end
    if (cmd.load) begin
      if (bad_r) begin
        out_status_code  <= CODE_FAIL;
        out_active_now   <= 1'b0;
        out_slot_state   <= 2'd0;
        out_tries        <= 8'd0;
        out_successes    <= 2'd0;
        out_slot_version <= 32'd0;
        out_slot_size    <= 32'd0;
        out_slot_crc     <= 32'd0;
      end else begin
        out_status_code  <= code;
        out_active_now   <= act_new;
        out_slot_state   <= rep_rec.status;
        out_tries        <= rep_rec.tries;
        out_successes    <= rep_rec.succ;
        out_slot_version <= rep_rec.version;
        out_slot_size    <= rep_rec.size;
        out_slot_crc     <= rep_rec.crc;
      end
    end
  end

endmodule
